// ===== rtl/trdt_pkg.sv =====
// ----------------------------------------------------------------------------
// trdt_pkg
// Shared types and constants of the triangle raster / depth test unit.
// ----------------------------------------------------------------------------
package trdt_pkg;

  localparam int unsigned MaxWidth   = 256;
  localparam int unsigned MaxHeight  = 256;
  localparam int unsigned StoreWords = MaxWidth * MaxHeight;
  localparam int unsigned AddrW      = (StoreWords > 1) ? $clog2(StoreWords) : 1;
  localparam int unsigned XW         = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
  localparam int unsigned YW         = (MaxHeight > 1) ? $clog2(MaxHeight) : 1;
  localparam int unsigned SizeW      = 9;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CountW     = 17;

  localparam logic [31:0] DepthInit = 32'h7FFF_FFFF;
  localparam logic [15:0] HalfPixel = 16'h8000;

  localparam logic [CfgIdxW-1:0] RegScreenWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegScreenHeight = 2'd1;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef struct packed {
    op_e                op;
    logic signed [31:0] vert0_x;
    logic signed [31:0] vert0_y;
    logic signed [31:0] vert0_z;
    logic signed [31:0] vert1_x;
    logic signed [31:0] vert1_y;
    logic signed [31:0] vert1_z;
    logic signed [31:0] vert2_x;
    logic signed [31:0] vert2_y;
    logic signed [31:0] vert2_z;
    logic [31:0]        fill_color;
    logic signed [31:0] clear_depth;
  } in_t;

  typedef struct packed {
    logic                culled;
    logic [CountW-1:0]   pixels_written;
    logic [31:0]         pixel_color;
    logic signed [31:0]  pixel_depth;
  } out_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [SizeW-1:0]   data;
  } cfg_t;

endpackage

// ===== rtl/trdt_if.sv =====
// ----------------------------------------------------------------------------
// trdt channel interfaces
// Valid/ready channels for draw commands, results and register writes.
// ----------------------------------------------------------------------------
interface trdt_in_if import trdt_pkg::*;;
  logic valid;
  logic ready;
  in_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface trdt_out_if import trdt_pkg::*;;
  logic valid;
  logic ready;
  out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface trdt_cfg_if import trdt_pkg::*;;
  logic valid;
  logic ready;
  cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/trdt_ram.sv =====
// ----------------------------------------------------------------------------
// trdt_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module trdt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256,
  localparam int unsigned AW   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/triangle_raster_depth_test_unit.sv =====
// Draw: setup on the serial 48-bit multiplier, then a walk over the bounding-box
//   pixels; each covered pixel takes 3 multiplies and a 64-step divider.
// One transaction at a time; input ready only while idle.
// After reset a sweep over all 65536 addresses fills both stores; no input is taken meanwhile.
// ----------------------------------------------------------------------------
// triangle_raster_depth_test_unit
// Edge-function triangle rasterizer with z-buffer, clear and pixel readback.
// ----------------------------------------------------------------------------
module triangle_raster_depth_test_unit import trdt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  trdt_in_if.sink    in_i,
  trdt_cfg_if.sink   cfg_i,
  trdt_out_if.source res_o
);

  typedef enum logic [10:0] {
    S_SWEEP = 11'b000_0000_0001,
    S_IDLE  = 11'b000_0000_0010,
    S_BOX   = 11'b000_0000_0100,
    S_MUL   = 11'b000_0000_1000,
    S_PIX   = 11'b000_0001_0000,
    S_ZMUL  = 11'b000_0010_0000,
    S_DIV   = 11'b000_0100_0000,
    S_CMP   = 11'b000_1000_0000,
    S_RDOUT = 11'b001_0000_0000,
    S_DONE  = 11'b010_0000_0000,
    S_SPARE = 11'b100_0000_0000
  } state_e;

  localparam logic [5:0] MulLast = 6'd47;
  localparam logic [5:0] ZLast   = 6'd3;
  localparam logic [5:0] DivLast = 6'd63;
  localparam logic [AddrW-1:0] SweepLast = AddrW'(StoreWords - 1);

  function automatic logic signed [15:0] min3(logic signed [15:0] a, logic signed [15:0] b,
                                              logic signed [15:0] c);
    logic signed [15:0] m;
    m = (a < b) ? a : b;
    return (c < m) ? c : m;
  endfunction

  function automatic logic signed [15:0] max3(logic signed [15:0] a, logic signed [15:0] b,
                                              logic signed [15:0] c);
    logic signed [15:0] m;
    m = (a > b) ? a : b;
    return (c > m) ? c : m;
  endfunction

  function automatic logic [AddrW-1:0] calc_addr(logic [YW-1:0] y, logic [XW-1:0] x,
                                                 logic [SizeW-1:0] w);
    logic [YW+SizeW:0] s;
    s = (YW + SizeW + 1)'(y) * (YW + SizeW + 1)'(w) + (YW + SizeW + 1)'(x);
    return AddrW'(s);
  endfunction

  function automatic logic [47:0] sx48(logic [31:0] v);
    return {{16{v[31]}}, v};
  endfunction

  state_e state_q, state_d;

  in_t               in_q;
  logic [SizeW-1:0]  w_q, h_q, weff, heff;
  logic [31:0]       fill_color_q, fill_depth_q;
  logic              sweep_res_q;
  logic [AddrW-1:0]  sweep_q;
  logic [5:0]        step_q;
  logic [2:0]        pi_q;
  logic [47:0]       mcand_q, mplier_q, macc_q;
  logic [47:0]       r_q [4];
  logic [47:0]       e_q [3];
  logic [47:0]       erow_q [3];
  logic [XW-1:0]     minx_q, maxx_q, px_q;
  logic [YW-1:0]     miny_q, maxy_q, py_q;
  logic              empty_q;
  logic signed [63:0] prod_q;
  logic signed [65:0] zacc_q;
  logic [63:0]       dvd_q;
  logic [31:0]       rem_q;
  logic              neg_q;
  logic [CountW-1:0] count_q, count_nx;
  logic              rd_ok_q;
  out_t              res_q, out_q;
  logic              out_valid_q;

  logic in_fire, out_load;
  logic [31:0] vx [3];
  logic [31:0] vy [3];
  logic [31:0] vz [3];

  assign vx[0] = in_q.vert0_x;
  assign vx[1] = in_q.vert1_x;
  assign vx[2] = in_q.vert2_x;
  assign vy[0] = in_q.vert0_y;
  assign vy[1] = in_q.vert1_y;
  assign vy[2] = in_q.vert2_y;
  assign vz[0] = in_q.vert0_z;
  assign vz[1] = in_q.vert1_z;
  assign vz[2] = in_q.vert2_z;

  assign weff = (32'(w_q) > MaxWidth) ? SizeW'(MaxWidth) : w_q;
  assign heff = (32'(h_q) > MaxHeight) ? SizeW'(MaxHeight) : h_q;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_load = (state_q == S_DONE) && (!out_valid_q || res_o.ready);

  // Bounding box
  logic signed [15:0] fmnx, fmxx, fmny, fmxy;
  logic signed [17:0] lox, hix, loy, hiy, wm1, hm1, mx1, my1;
  logic               box_empty;

  always_comb begin
    fmnx = min3(16'(in_q.vert0_x >>> 16), 16'(in_q.vert1_x >>> 16), 16'(in_q.vert2_x >>> 16));
    fmxx = max3(16'(in_q.vert0_x >>> 16), 16'(in_q.vert1_x >>> 16), 16'(in_q.vert2_x >>> 16));
    fmny = min3(16'(in_q.vert0_y >>> 16), 16'(in_q.vert1_y >>> 16), 16'(in_q.vert2_y >>> 16));
    fmxy = max3(16'(in_q.vert0_y >>> 16), 16'(in_q.vert1_y >>> 16), 16'(in_q.vert2_y >>> 16));
    wm1  = signed'(18'(weff)) - 18'sd1;
    hm1  = signed'(18'(heff)) - 18'sd1;
    mx1  = 18'(fmxx) + 18'sd1;
    my1  = 18'(fmxy) + 18'sd1;
    lox  = fmnx[15] ? 18'sd0 : 18'(fmnx);
    loy  = fmny[15] ? 18'sd0 : 18'(fmny);
    hix  = (mx1 > wm1) ? wm1 : mx1;
    hiy  = (my1 > hm1) ? hm1 : my1;
    box_empty = (lox > hix) || (loy > hiy);
  end

  // Shared serial multiplier operand select
  logic [2:0]  mul_sel;
  logic [1:0]  ja, jb;
  logic [47:0] cxv, cyv, op_a, op_b, macc_nx, rv;
  logic        mul_last;

  always_comb begin
    mul_sel = (state_q == S_BOX) ? 3'd0 : pi_q + 3'd1;
    cxv = 48'({minx_q, HalfPixel});
    cyv = 48'({miny_q, HalfPixel});
    unique case (mul_sel[2:1])
      2'd0: begin
        ja = 2'd0; jb = 2'd1;
        cxv = sx48(vx[2]);
        cyv = sx48(vy[2]);
      end
      2'd1: begin ja = 2'd1; jb = 2'd2; end
      2'd2: begin ja = 2'd2; jb = 2'd0; end
      default: begin ja = 2'd0; jb = 2'd1; end
    endcase
    op_a = mul_sel[0] ? cyv - sx48(vy[ja]) : cxv - sx48(vx[ja]);
    op_b = mul_sel[0] ? sx48(vx[jb]) - sx48(vx[ja]) : sx48(vy[jb]) - sx48(vy[ja]);
    macc_nx  = macc_q + (mplier_q[0] ? mcand_q : 48'd0);
    mul_last = (step_q == MulLast);
    rv = pi_q[0] ? r_q[pi_q[2:1]] - macc_nx : macc_nx;
  end

  logic area_le0;
  assign area_le0 = rv[47] || (rv[47:16] == 32'd0);

  // Edge steps
  logic [47:0] dxs [3];
  logic [47:0] dys [3];
  logic [2:0]  eneg;

  always_comb begin
    dxs[0] = {vx[2] - vx[1], 16'h0};
    dys[0] = {vy[2] - vy[1], 16'h0};
    dxs[1] = {vx[0] - vx[2], 16'h0};
    dys[1] = {vy[0] - vy[2], 16'h0};
    dxs[2] = {vx[1] - vx[0], 16'h0};
    dys[2] = {vy[1] - vy[0], 16'h0};
    eneg   = {e_q[2][47], e_q[1][47], e_q[0][47]};
  end

  logic covered, row_end, box_end, adv;
  logic [AddrW-1:0] pix_addr;

  assign covered  = (eneg == 3'b000);
  assign row_end  = (px_q == maxx_q);
  assign box_end  = row_end && (py_q == maxy_q);
  assign adv      = ((state_q == S_PIX) && !covered) || (state_q == S_CMP);
  assign pix_addr = calc_addr(py_q, px_q, weff);

  // Depth interpolation
  logic signed [31:0] zsel, esel;
  logic signed [65:0] zsum, zabs;
  logic [32:0]        dtry;
  logic               dge;
  logic [31:0]        qv, depth_new, color_rd, depth_rd;
  logic               depth_less;

  always_comb begin
    unique case (step_q[1:0])
      2'd0:    begin zsel = vz[0]; esel = e_q[0][47:16]; end
      2'd1:    begin zsel = vz[1]; esel = e_q[1][47:16]; end
      default: begin zsel = vz[2]; esel = e_q[2][47:16]; end
    endcase
    zsum = zacc_q + 66'(prod_q);
    zabs = zsum[65] ? -zsum : zsum;
    dtry = {rem_q, dvd_q[63]};
    dge  = (dtry >= {1'b0, r_q[0][47:16]});
    qv   = dvd_q[31:0];
    depth_new  = neg_q ? (32'd0 - qv) : qv;
    depth_less = signed'(depth_new) < signed'(depth_rd);
  end

  assign count_nx = count_q + CountW'((state_q == S_CMP) && depth_less);

  // Read address from the incoming transaction
  logic signed [15:0] rdx, rdy;
  logic               rd_ok;
  logic [AddrW-1:0]   rd_addr;

  always_comb begin
    rdx = in_i.data.vert0_x[31:16];
    rdy = in_i.data.vert0_y[31:16];
    rd_ok = !rdx[15] && !rdy[15] && (rdx[14:0] < 15'(weff)) && (rdy[14:0] < 15'(heff));
    rd_addr = calc_addr(rdy[YW-1:0], rdx[XW-1:0], weff);
  end

  // Stores
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [31:0]      color_wd, depth_wd;

  always_comb begin
    ram_we    = (state_q == S_SWEEP) || ((state_q == S_CMP) && depth_less);
    ram_waddr = (state_q == S_SWEEP) ? sweep_q : pix_addr;
    color_wd  = (state_q == S_SWEEP) ? fill_color_q : in_q.fill_color;
    depth_wd  = (state_q == S_SWEEP) ? fill_depth_q : depth_new;
    ram_re    = (in_fire && (in_i.data.op == OP_READ)) || ((state_q == S_PIX) && covered);
    ram_raddr = (state_q == S_IDLE) ? rd_addr : pix_addr;
  end

  trdt_ram #(.Width(32), .Depth(StoreWords)) u_color_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (color_wd),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (color_rd)
  );

  trdt_ram #(.Width(32), .Depth(StoreWords)) u_depth_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (depth_wd),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (depth_rd)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_SWEEP: if (sweep_q == SweepLast) state_d = sweep_res_q ? S_DONE : S_IDLE;
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_i.data.op)
            OP_CLEAR: state_d = S_SWEEP;
            OP_DRAW:  state_d = S_BOX;
            OP_READ:  state_d = S_RDOUT;
            OP_NONE:  state_d = S_DONE;
          endcase
        end
      end
      S_BOX: state_d = S_MUL;
      S_MUL: begin
        if (mul_last) begin
          if ((pi_q == 3'd1) && (area_le0 || empty_q)) state_d = S_DONE;
          else if (pi_q == 3'd7) state_d = S_PIX;
        end
      end
      S_PIX:   state_d = covered ? S_ZMUL : (box_end ? S_DONE : S_PIX);
      S_ZMUL:  if (step_q == ZLast) state_d = S_DIV;
      S_DIV:   if (step_q == DivLast) state_d = S_CMP;
      S_CMP:   state_d = box_end ? S_DONE : S_PIX;
      S_RDOUT: state_d = S_DONE;
      S_DONE:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_SWEEP;
      w_q          <= SizeW'(MaxWidth);
      h_q          <= SizeW'(MaxHeight);
      fill_color_q <= '0;
      fill_depth_q <= DepthInit;
      sweep_res_q  <= 1'b0;
      sweep_q      <= '0;
      step_q       <= '0;
      pi_q         <= '0;
      px_q         <= '0;
      py_q         <= '0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.data.index == RegScreenWidth)  w_q <= cfg_i.data.data;
        if (cfg_i.data.index == RegScreenHeight) h_q <= cfg_i.data.data;
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (res_o.ready) out_valid_q <= 1'b0;
      count_q <= count_nx;
      unique case (state_q)
        S_SWEEP: sweep_q <= sweep_q + AddrW'(1);
        S_IDLE: begin
          if (in_fire && (in_i.data.op == OP_CLEAR)) begin
            sweep_q      <= '0;
            sweep_res_q  <= 1'b1;
            fill_color_q <= in_i.data.fill_color;
            fill_depth_q <= in_i.data.clear_depth;
          end
        end
        S_BOX: begin
          step_q  <= '0;
          pi_q    <= '0;
          count_q <= '0;
        end
        S_MUL: begin
          if (mul_last) begin
            step_q <= '0;
            pi_q   <= pi_q + 3'd1;
            if (pi_q == 3'd7) begin
              px_q <= minx_q;
              py_q <= miny_q;
            end
          end else begin
            step_q <= step_q + 6'd1;
          end
        end
        S_PIX:  step_q <= '0;
        S_ZMUL: step_q <= (step_q == ZLast) ? 6'd0 : step_q + 6'd1;
        S_DIV:  step_q <= step_q + 6'd1;
        default: ;
      endcase
      if (adv && !box_end) begin
        if (row_end) begin
          px_q <= minx_q;
          py_q <= py_q + YW'(1);
        end else begin
          px_q <= px_q + XW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= res_q;
    unique case (state_q)
      S_SWEEP: if (sweep_q == SweepLast) res_q <= '0;
      S_IDLE: begin
        if (in_fire) begin
          in_q    <= in_i.data;
          rd_ok_q <= rd_ok;
          res_q   <= '0;
        end
      end
      S_BOX: begin
        minx_q   <= lox[XW-1:0];
        maxx_q   <= hix[XW-1:0];
        miny_q   <= loy[YW-1:0];
        maxy_q   <= hiy[YW-1:0];
        empty_q  <= box_empty;
        mcand_q  <= op_a;
        mplier_q <= op_b;
        macc_q   <= '0;
      end
      S_MUL: begin
        if (mul_last) begin
          r_q[pi_q[2:1]] <= rv;
          mcand_q  <= op_a;
          mplier_q <= op_b;
          macc_q   <= '0;
          if (pi_q == 3'd1) res_q <= '{culled: area_le0, default: '0};
          if (pi_q == 3'd7) begin
            e_q[0]    <= r_q[1];
            e_q[1]    <= r_q[2];
            e_q[2]    <= rv;
            erow_q[0] <= r_q[1];
            erow_q[1] <= r_q[2];
            erow_q[2] <= rv;
          end
        end else begin
          macc_q   <= macc_nx;
          mcand_q  <= {mcand_q[46:0], 1'b0};
          mplier_q <= {1'b0, mplier_q[47:1]};
        end
      end
      S_PIX: if (covered) zacc_q <= '0;
      S_ZMUL: begin
        if (step_q != ZLast) prod_q <= zsel * esel;
        if (step_q != 6'd0) zacc_q <= zsum;
        if (step_q == ZLast) begin
          neg_q <= zsum[65];
          dvd_q <= zabs[63:0];
          rem_q <= '0;
        end
      end
      S_DIV: begin
        rem_q <= dge ? 32'(dtry - {1'b0, r_q[0][47:16]}) : dtry[31:0];
        dvd_q <= {dvd_q[62:0], dge};
      end
      S_RDOUT: begin
        res_q.pixel_color <= rd_ok_q ? color_rd : 32'd0;
        res_q.pixel_depth <= rd_ok_q ? depth_rd : 32'd0;
      end
      default: ;
    endcase
    if (adv) begin
      if (box_end) begin
        res_q <= '{pixels_written: count_nx, default: '0};
      end else begin
        for (int k = 0; k < 3; k++) begin
          if (row_end) begin
            erow_q[k] <= erow_q[k] - dxs[k];
            e_q[k]    <= erow_q[k] - dxs[k];
          end else begin
            e_q[k] <= e_q[k] + dys[k];
          end
        end
      end
    end
  end

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_i.ready) else $error("input taken while busy");
  a_culled_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.data.culled) |-> (res_o.data.pixels_written == '0))
    else $error("culled draw reports pixels");
  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ((state_q == S_SWEEP) || (state_q == S_CMP)))
    else $error("store written outside sweep or depth test");
  a_div_area_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (!r_q[0][47] && (r_q[0][47:16] != 32'd0)))
    else $error("divide by non-positive area");
`endif

endmodule

// ===== test/triangle_raster_depth_test_unit_test.sv =====
// ----------------------------------------------------------------------------
// triangle_raster_depth_test_unit_test
// Self-checking bench: directed draw/clear/read transactions and random
// triangles over several screen sizes, checked against an in-bench z-buffer
// rasterizer, with random stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module triangle_raster_depth_test_unit_test;
  import trdt_pkg::*;

  localparam longint CycleLimit = 12_000_000;

  typedef struct {
    in_t  item;
    bit   known;
    out_t res;
  } dir_row_t;

  typedef struct {
    int unsigned w;
    int unsigned h;
    int unsigned span;
    int unsigned count;
    bit          noise;
    bit          clear;
  } phase_t;

  logic clk_i;
  logic rst_ni;

  trdt_in_if  in_ch ();
  trdt_cfg_if cfg_ch ();
  trdt_out_if res_ch ();

  triangle_raster_depth_test_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .cfg_i  (cfg_ch),
    .res_o  (res_ch)
  );

  logic [31:0]        color_mem [StoreWords];
  logic signed [31:0] depth_mem [StoreWords];
  logic [SizeW-1:0]   scr_w_reg;
  logic [SizeW-1:0]   scr_h_reg;
  out_t               pending_q [$];
  int                 err_cnt;
  longint             cycle_cnt;
  bit                 calm;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic signed [31:0] edge_val(longint ax, longint ay, longint bx,
                                                  longint by, longint cx, longint cy);
    logic [63:0] r;
    r = (cx - ax) * (by - ay) - (cy - ay) * (bx - ax);
    return r[47:16];
  endfunction

  function automatic longint eff_w();
    return (scr_w_reg > MaxWidth) ? MaxWidth : scr_w_reg;
  endfunction

  function automatic longint eff_h();
    return (scr_h_reg > MaxHeight) ? MaxHeight : scr_h_reg;
  endfunction

  function automatic out_t raster_predict(in_t t);
    out_t               o;
    longint             x0, y0, z0, x1, y1, z1, x2, y2, z2;
    longint             w, h, area, minx, maxx, miny, maxy, px, py, idx, cx, cy;
    longint             e0, e1, e2;
    longint unsigned    pos, neg, q;
    logic signed [31:0] dep;
    int unsigned        cnt;
    o = '0;
    w = eff_w();
    h = eff_h();
    x0 = t.vert0_x; y0 = t.vert0_y; z0 = t.vert0_z;
    x1 = t.vert1_x; y1 = t.vert1_y; z1 = t.vert1_z;
    x2 = t.vert2_x; y2 = t.vert2_y; z2 = t.vert2_z;
    case (t.op)
      OP_CLEAR: begin
        for (int i = 0; i < StoreWords; i++) begin
          color_mem[i] = t.fill_color;
          depth_mem[i] = t.clear_depth;
        end
      end
      OP_DRAW: begin
        area = edge_val(x0, y0, x1, y1, x2, y2);
        if (area <= 0) begin
          o.culled = 1'b1;
        end else begin
          minx = x0 >>> 16; maxx = minx;
          miny = y0 >>> 16; maxy = miny;
          if ((x1 >>> 16) < minx) minx = x1 >>> 16;
          if ((x2 >>> 16) < minx) minx = x2 >>> 16;
          if ((x1 >>> 16) > maxx) maxx = x1 >>> 16;
          if ((x2 >>> 16) > maxx) maxx = x2 >>> 16;
          if ((y1 >>> 16) < miny) miny = y1 >>> 16;
          if ((y2 >>> 16) < miny) miny = y2 >>> 16;
          if ((y1 >>> 16) > maxy) maxy = y1 >>> 16;
          if ((y2 >>> 16) > maxy) maxy = y2 >>> 16;
          maxx += 1; maxy += 1;
          if (minx < 0) minx = 0;
          if (miny < 0) miny = 0;
          if (maxx > w - 1) maxx = w - 1;
          if (maxy > h - 1) maxy = h - 1;
          cnt = 0;
          for (py = miny; py <= maxy; py++) begin
            for (px = minx; px <= maxx; px++) begin
              cx = px * 65536 + 32768;
              cy = py * 65536 + 32768;
              e0 = edge_val(x1, y1, x2, y2, cx, cy);
              e1 = edge_val(x2, y2, x0, y0, cx, cy);
              e2 = edge_val(x0, y0, x1, y1, cx, cy);
              if (e0 < 0 || e1 < 0 || e2 < 0) continue;
              pos = 0; neg = 0;
              if (z0 >= 0) pos += z0 * e0; else neg += (-z0) * e0;
              if (z1 >= 0) pos += z1 * e1; else neg += (-z1) * e1;
              if (z2 >= 0) pos += z2 * e2; else neg += (-z2) * e2;
              if (pos >= neg) begin
                q = (pos - neg) / longint'(area);
                dep = q[31:0];
              end else begin
                q = (neg - pos) / longint'(area);
                dep = -q[31:0];
              end
              idx = py * w + px;
              if (dep < depth_mem[idx]) begin
                depth_mem[idx] = dep;
                color_mem[idx] = t.fill_color;
                cnt++;
              end
            end
          end
          o.pixels_written = cnt[CountW-1:0];
        end
      end
      OP_READ: begin
        px = x0 >>> 16;
        py = y0 >>> 16;
        if (px >= 0 && px < w && py >= 0 && py < h) begin
          o.pixel_color = color_mem[py * w + px];
          o.pixel_depth = depth_mem[py * w + px];
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic in_t mk(op_e op, int x0, int y0, int z0, int x1, int y1, int z1,
                             int x2, int y2, int z2, int color, int cd);
    in_t t;
    t.op = op;
    t.vert0_x = x0; t.vert0_y = y0; t.vert0_z = z0;
    t.vert1_x = x1; t.vert1_y = y1; t.vert1_z = z1;
    t.vert2_x = x2; t.vert2_y = y2; t.vert2_z = z2;
    t.fill_color = color;
    t.clear_depth = cd;
    return t;
  endfunction

  function automatic out_t mk_res(bit c, int n, int color, int dep);
    out_t o;
    o.culled = c;
    o.pixels_written = n;
    o.pixel_color = color;
    o.pixel_depth = dep;
    return o;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    out_t exp_r;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, res_ch.data);
        err_cnt++;
      end else begin
        exp_r = pending_q.pop_front();
        if (res_ch.data.culled !== exp_r.culled) begin
          $display("%0t: culled exp %0d got %0d", $time, exp_r.culled, res_ch.data.culled);
          err_cnt++;
        end
        if (res_ch.data.pixels_written !== exp_r.pixels_written) begin
          $display("%0t: pixels_written exp %0d got %0d", $time,
                   exp_r.pixels_written, res_ch.data.pixels_written);
          err_cnt++;
        end
        if (res_ch.data.pixel_color !== exp_r.pixel_color) begin
          $display("%0t: pixel_color exp %h got %h", $time,
                   exp_r.pixel_color, res_ch.data.pixel_color);
          err_cnt++;
        end
        if (res_ch.data.pixel_depth !== exp_r.pixel_depth) begin
          $display("%0t: pixel_depth exp %h got %h", $time,
                   exp_r.pixel_depth, res_ch.data.pixel_depth);
          err_cnt++;
        end
      end
    end
  end

  // result-side stalls
  initial begin
    int stall;
    stall = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        stall--;
      end else begin
        res_ch.ready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0)
          stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80) : $urandom_range(1, 3);
      end
    end
  end

  task automatic send_item(input in_t item, input bit known, input out_t res);
    int   gap;
    out_t p;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= item;
    do @(posedge clk_i); while (!in_ch.ready);
    p = raster_predict(item);
    pending_q.push_back(known ? res : p);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [SizeW-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= '{index: idx, data: val};
    do @(posedge clk_i); while (!cfg_ch.ready);
    if (idx == RegScreenWidth) scr_w_reg = val;
    else if (idx == RegScreenHeight) scr_h_reg = val;
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic in_t rand_draw(int unsigned span);
    in_t    t;
    longint w, h, bx, by;
    int     xs [3];
    int     ys [3];
    int     tmp;
    w = eff_w();
    h = eff_h();
    bx = longint'($urandom_range(0, w + 3)) - 2;
    by = longint'($urandom_range(0, h + 3)) - 2;
    for (int k = 0; k < 3; k++) begin
      xs[k] = int'((bx + $urandom_range(0, span)) * 65536) + $urandom_range(0, 65535);
      ys[k] = int'((by + $urandom_range(0, span)) * 65536) + $urandom_range(0, 65535);
    end
    if (edge_val(xs[0], ys[0], xs[1], ys[1], xs[2], ys[2]) < 0
        && $urandom_range(0, 9) < 8) begin
      tmp = xs[1]; xs[1] = xs[2]; xs[2] = tmp;
      tmp = ys[1]; ys[1] = ys[2]; ys[2] = tmp;
    end
    t = mk(OP_DRAW, xs[0], ys[0], 0, xs[1], ys[1], 0, xs[2], ys[2], 0,
           $urandom, $urandom);
    if ($urandom_range(0, 3) == 0) begin
      t.vert0_z = $urandom; t.vert1_z = $urandom; t.vert2_z = $urandom;
    end else begin
      t.vert0_z = int'($urandom_range(0, 4000)) - 2000;
      t.vert1_z = int'($urandom_range(0, 4000)) - 2000;
      t.vert2_z = int'($urandom_range(0, 4000)) - 2000;
    end
    return t;
  endfunction

  function automatic in_t rand_read();
    in_t t;
    t = mk(OP_READ, 0, 0, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom);
    t.vert0_x = int'((longint'($urandom_range(0, eff_w() + 1)) - 1) * 65536)
                + $urandom_range(0, 65535);
    t.vert0_y = int'((longint'($urandom_range(0, eff_h() + 1)) - 1) * 65536)
                + $urandom_range(0, 65535);
    return t;
  endfunction

  initial begin
    dir_row_t rows [$];
    phase_t   phases [$];
    in_t      t;
    int       r;

    err_cnt = 0;
    cycle_cnt = 0;
    calm = 1'b0;
    scr_w_reg = 9'd256;
    scr_h_reg = 9'd256;
    for (int i = 0; i < StoreWords; i++) begin
      color_mem[i] = '0;
      depth_mem[i] = DepthInit;
    end
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    rows.push_back('{mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                     mk_res(0, 0, 0, DepthInit)});
    rows.push_back('{mk(OP_READ, 32'h00FF_FFFF, 32'h00FF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                     mk_res(0, 0, 0, DepthInit)});
    rows.push_back('{mk(OP_READ, 32'hFFFF_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                     mk_res(0, 0, 0, 0)});
    rows.push_back('{mk(OP_READ, 32'h0100_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                     mk_res(0, 0, 0, 0)});
    rows.push_back('{mk(OP_NONE, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1), 1,
                     mk_res(0, 0, 0, 0)});
    rows.push_back('{mk(OP_DRAW, 0, 0, 5, 32'h4_0000, 0, 5, 0, 32'h4_0000, 5, 1, 0), 1,
                     mk_res(1, 0, 0, 0)});
    rows.push_back('{mk(OP_DRAW, 32'h3_8000, 32'h3_8000, 0, 32'h3_8000, 32'h3_8000, 0,
                        32'h3_8000, 32'h3_8000, 0, 1, 0), 1, mk_res(1, 0, 0, 0)});
    rows.push_back('{mk(OP_DRAW, 0, 0, 100, 0, 32'h4_0000, 100, 32'h4_0000, 0, 100,
                        32'hA5A5_5A5A, 0), 0, '0});
    rows.push_back('{mk(OP_READ, 32'h1_0000, 32'h1_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
    rows.push_back('{mk(OP_DRAW, 0, 0, 200, 0, 32'h4_0000, 200, 32'h4_0000, 0, 200,
                        32'h1234_5678, 0), 1, mk_res(0, 0, 0, 0)});
    rows.push_back('{mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, -1, 32'h8000_0000), 1,
                     mk_res(0, 0, 0, 0)});
    rows.push_back('{mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                     mk_res(0, 0, -1, 32'h8000_0000)});
    rows.push_back('{mk(OP_DRAW, 32'h10_0000, 32'h10_0000, 32'h8000_0000, 32'h10_0000,
                        32'h16_0000, 32'h8000_0000, 32'h16_0000, 32'h10_0000,
                        32'h8000_0000, 7, 0), 0, '0});
    rows.push_back('{mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, DepthInit), 1,
                     mk_res(0, 0, 0, 0)});
    rows.push_back('{mk(OP_DRAW, 32'h2_8000, 32'h1_0000, -7, 32'h0_4000, 32'h7_C000, 9,
                        32'h9_0000, 32'h6_0000, 3, 32'hFFFF_0001, 0), 0, '0});
    rows.push_back('{mk(OP_READ, 32'h3_0000, 32'h4_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, '0});
    foreach (rows[i]) send_item(rows[i].item, rows[i].known, rows[i].res);

    phases.push_back('{256, 256, 6, 250, 0, 0});
    phases.push_back('{16, 12, 20, 200, 1, 1});
    phases.push_back('{1, 1, 2, 80, 1, 0});
    phases.push_back('{0, 5, 3, 40, 1, 0});
    phases.push_back('{300, 511, 5, 150, 0, 1});
    phases.push_back('{255, 1, 4, 100, 0, 0});
    phases.push_back('{37, 200, 8, 200, 0, 0});
    phases.push_back('{256, 256, 3, 130, 0, 1});

    foreach (phases[p]) begin
      drain();
      write_reg(RegScreenWidth, phases[p].w);
      write_reg(RegScreenHeight, phases[p].h);
      calm = (p % 3 == 2);
      if (phases[p].clear)
        send_item(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, $urandom, $urandom), 1, '0);
      for (int n = 0; n < phases[p].count; n++) begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          t = rand_draw(phases[p].span);
        end else if (r < 90) begin
          t = rand_read();
        end else if (r < 93) begin
          t = mk(OP_NONE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom, $urandom);
        end else if (phases[p].noise) begin
          t = mk(OP_DRAW, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom, $urandom);
          if ($urandom_range(0, 1) == 1) t.op = OP_READ;
        end else begin
          t = rand_draw(phases[p].span);
        end
        send_item(t, 0, '0);
      end
    end

    drain();
    repeat (100) @(negedge clk_i);
    if (err_cnt == 0 && pending_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== triangle_raster_depth_test_unit.f =====
rtl/trdt_pkg.sv
rtl/trdt_if.sv
rtl/trdt_ram.sv
rtl/triangle_raster_depth_test_unit.sv
test/triangle_raster_depth_test_unit_test.sv
